FILE: rtl/core/aes256ctr_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 CTR keystream package
// Shared types, constants and the byte substitution, row shift and column mix functions.
// ----------------------------------------------------------------------------
package aes256ctr_pkg;

    localparam int BLOCK_W = 128;
    localparam int KEY_W   = 256;
    localparam int CNT_W   = 5;
    localparam logic [CNT_W-1:0] MAX_BYTES = 5'd16;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } reg_idx_t;

    // item travelling down the round chain
    typedef struct packed {
        logic                 valid;
        logic [BLOCK_W-1:0]   state;
        logic [CNT_W-1:0]     count;
    } cell_bus_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    // SubBytes then ShiftRows
    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BLOCK_W-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

FILE: rtl/core/aes256_ctr_keystream_unit.sv
// ----------------------------------------------------------------------------
// AES-256 CTR keystream unit
// Counter-mode keystream generator built as a chain of round cells.
// ----------------------------------------------------------------------------
// Takes one item per clock whenever start is high (busy is always low) and
// gives its keystream block on done after the initial key add register and
// one round cell per round. Results come in request order, one per cycle at
// most, and cannot be held off. The key schedule is a chain of seven
// registered expansion cells fed from the key registers; a new round key
// reaches round r through the key register and r/2 expansion cells, always
// ahead of the item, so a key written while no item is in flight applies to
// the very next start. wanted_bytes above 16 is treated as 16; bytes at or
// beyond the count read as zero.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_unit
    import aes256ctr_pkg::*;
#(
    parameter int ROUND_COUNT = 14
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         start,
    output logic         busy,
    input  logic [63:0]  iv_upper,
    input  logic [31:0]  iv_middle,
    input  logic [31:0]  block_number,
    input  logic [4:0]   wanted_bytes,
    output logic         done,
    output logic [63:0]  stream_upper,
    output logic [63:0]  stream_lower,
    output logic [4:0]   byte_count
);

    localparam int KCELLS = (ROUND_COUNT + 1) / 2;

    logic [63:0]        key_reg [4];
    logic [KEY_W-1:0]   sched [KCELLS+1];
    logic [BLOCK_W-1:0] rkey [ROUND_COUNT+1];
    cell_bus_t          chain [ROUND_COUNT+1];
    logic [7:0]         rcon [KCELLS];
    logic               wr_en;
    reg_idx_t           wr_idx;
    logic [CNT_W-1:0]   sat_count;
    logic [BLOCK_W-1:0] masked;

    // write a key register
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[4:3]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_KEY0: key_reg[0] <= pwdata;
                REG_KEY1: key_reg[1] <= pwdata;
                REG_KEY2: key_reg[2] <= pwdata;
                REG_KEY3: key_reg[3] <= pwdata;
                default:  key_reg[0] <= key_reg[0];
            endcase
        end
    end

    assign prdata = key_reg[paddr[4:3]];

    // key schedule chain
    assign sched[0] = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};

    always_comb
    begin
        rcon[0] = 8'h01;
        for (int k = 1; k < KCELLS; k++)
            rcon[k] = xtime(rcon[k-1]);
    end

    for (genvar k = 0; k < KCELLS; k++)
    begin : g_key
        aes256ctr_key_cell u_key (
            .clk     (clk),
            .key_in  (sched[k]),
            .rcon    (rcon[k]),
            .key_out (sched[k+1])
        );
    end

    for (genvar r = 0; r <= ROUND_COUNT; r++)
    begin : g_rkey
        assign rkey[r] = (r % 2 == 0) ? sched[r/2][KEY_W-1 -: BLOCK_W]
                                      : sched[r/2][BLOCK_W-1:0];
    end

    // initial key add stage
    assign busy      = 1'b0;
    assign sat_count = (wanted_bytes > MAX_BYTES) ? MAX_BYTES : wanted_bytes;

    logic               v0_reg;
    logic [BLOCK_W-1:0] s0_reg;
    logic [CNT_W-1:0]   c0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= {iv_upper, iv_middle, block_number} ^ rkey[0];
        c0_reg <= sat_count;
    end

    assign chain[0] = '{valid: v0_reg, state: s0_reg, count: c0_reg};

    // round cells
    for (genvar r = 1; r <= ROUND_COUNT; r++)
    begin : g_round
        aes256ctr_round_cell #(.LAST(r == ROUND_COUNT)) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .bus_in    (chain[r-1]),
            .round_key (rkey[r]),
            .bus_out   (chain[r])
        );
    end

    // drop unwanted bytes
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            masked[BLOCK_W-1-8*i -: 8] = (CNT_W'(i) < chain[ROUND_COUNT].count)
                ? chain[ROUND_COUNT].state[BLOCK_W-1-8*i -: 8] : 8'h00;
    end

    assign done         = chain[ROUND_COUNT].valid;
    assign stream_upper = masked[127:64];
    assign stream_lower = masked[63:0];
    assign byte_count   = chain[ROUND_COUNT].count;

    // every start yields a result on done once it has passed the whole chain
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(ROUND_COUNT+1) done)
        else $error("result missing after start");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, ROUND_COUNT+1))
        else $error("result without start");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> byte_count <= MAX_BYTES)
        else $error("byte count above 16");

endmodule

FILE: rtl/core/aes256ctr_key_cell.sv
// ----------------------------------------------------------------------------
// AES-256 key schedule cell
// One step of the key expansion: takes eight schedule words, gives the next
// eight and registers them. A chain of these holds the whole schedule.
// ----------------------------------------------------------------------------
module aes256ctr_key_cell
    import aes256ctr_pkg::*;
(
    input  logic             clk,
    input  logic [KEY_W-1:0] key_in,
    input  logic [7:0]       rcon,
    output logic [KEY_W-1:0] key_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [31:0]      w [8];
    logic [31:0]      n [8];

    // derive the next eight words
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            w[i] = key_in[KEY_W-1-32*i -: 32];
        n[0] = w[0] ^ sub_word({w[7][23:0], w[7][31:24]}) ^ {rcon, 24'h0};
        n[1] = w[1] ^ n[0];
        n[2] = w[2] ^ n[1];
        n[3] = w[3] ^ n[2];
        n[4] = w[4] ^ sub_word(n[3]);
        n[5] = w[5] ^ n[4];
        n[6] = w[6] ^ n[5];
        n[7] = w[7] ^ n[6];
        for (int i = 0; i < 8; i++)
            key_next[KEY_W-1-32*i -: 32] = n[i];
    end

    // hold the schedule step
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;

endmodule

FILE: rtl/core/aes256ctr_round_cell.sv
// ----------------------------------------------------------------------------
// AES-256 round cell
// One cipher round with its round key added, registered; the item then
// moves on to the neighbor cell.
// ----------------------------------------------------------------------------
module aes256ctr_round_cell
    import aes256ctr_pkg::*;
#(
    parameter bit LAST = 1'b0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_bus_t          bus_in,
    input  logic [BLOCK_W-1:0] round_key,
    output cell_bus_t          bus_out
);

    logic               valid_reg;
    logic [BLOCK_W-1:0] state_reg;
    logic [BLOCK_W-1:0] state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [BLOCK_W-1:0] shifted;

    // run the round; the final round has no column mix
    always_comb
    begin
        shifted = sub_shift(bus_in.state);
        if (LAST)
            state_next = shifted ^ round_key;
        else
            state_next = mix_columns(shifted) ^ round_key;
    end

    // advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= bus_in.valid;
    end

    // advance the payload
    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        count_reg <= bus_in.count;
    end

    assign bus_out = '{valid: valid_reg, state: state_reg, count: count_reg};

endmodule
